FILE: hw/rtl/scd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the source code detector.
// No dependencies; every other file in this block imports it, except scd_checker.
package scd_pkg;

    localparam int DEPTH_BITS = 16;

    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [2:0][DEPTH_BITS-1:0] depth_set_t;

    localparam depth_t DEPTH_MAX = '1;

    typedef enum logic [2:0] {
        VERDICT_EMPTY   = 3'd0,
        VERDICT_BRACKET = 3'd1,
        VERDICT_INCLUDE = 3'd2,
        VERDICT_MAIN    = 3'd3,
        VERDICT_TEXT    = 3'd4
    } verdict_t;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } beat_t;

    // One result item on its way to the output register.
    typedef struct packed {
        logic     is_code;
        verdict_t verdict;
    } result_t;

endpackage

FILE: hw/rtl/scd_in_stage.sv
`timescale 1ns / 1ps
// Input register of the source code detector: holds one accepted beat.
// Depends on scd_pkg for the beat type.
module scd_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,
    input  logic          advance,
    output logic          beat_valid,
    output scd_pkg::beat_t beat
);
    import scd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg.data_byte <= s_tdata;
            beat_reg.last      <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

FILE: hw/rtl/scd_classifier.sv
`timescale 1ns / 1ps
// Per-message scan state of the source code detector: bracket depths,
// include matcher and the main() recognizer. Depends on scd_pkg.
module scd_classifier (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  scd_pkg::beat_t   beat,
    output logic             res_valid,
    output scd_pkg::result_t result
);
    import scd_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_OPEN_R = 7'b0000010,
        PH_IN_R   = 7'b0000100,
        PH_OPEN_C = 7'b0001000,
        PH_IN_C   = 7'b0010000,
        PH_FOUND  = 7'b0100000,
        PH_FAIL   = 7'b1000000
    } phase_t;

    typedef struct packed {
        depth_set_t depth;
        logic       ok;
    } count_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [3:0] INCL_LEN = 4'd8;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    function automatic logic [7:0] incl_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_HASH;
            3'd1:    c = "i";
            3'd2:    c = "n";
            3'd3:    c = "c";
            3'd4:    c = "l";
            3'd5:    c = "u";
            3'd6:    c = "d";
            default: c = "e";
        endcase
        return c;
    endfunction

    // Apply one byte to a set of (), [], {} depths; ok drops on underflow or overflow.
    function automatic count_t count_bracket(input depth_set_t d, input logic [7:0] b);
        count_t     r;
        logic       hit;
        logic       up;
        logic [1:0] k;
        r.depth = d;
        r.ok    = 1'b1;
        hit     = 1'b1;
        up      = 1'b0;
        k       = 2'd0;
        case (b)
            CH_LPAREN:  begin k = 2'd0; up = 1'b1; end
            CH_RPAREN:  begin k = 2'd0; up = 1'b0; end
            CH_LSQUARE: begin k = 2'd1; up = 1'b1; end
            CH_RSQUARE: begin k = 2'd1; up = 1'b0; end
            CH_LCURLY:  begin k = 2'd2; up = 1'b1; end
            CH_RCURLY:  begin k = 2'd2; up = 1'b0; end
            default:    hit = 1'b0;
        endcase
        if (hit) begin
            if (up) begin
                if (d[k] == DEPTH_MAX) r.ok = 1'b0;
                else r.depth[k] = d[k] + 1'b1;
            end else begin
                if (d[k] == '0) r.ok = 1'b0;
                else r.depth[k] = d[k] - 1'b1;
            end
        end
        return r;
    endfunction

    depth_set_t       depth_reg, depth_next;
    logic             bracket_error_reg, bracket_error_next;
    logic [3:0]       incl_prog_reg, incl_prog_next;
    logic             include_seen_reg, include_seen_next;
    logic [4:0][7:0]  recent_reg, recent_next;
    logic [3:0][7:0]  type_win_reg, type_win_next;
    logic [2:0]       chars_before_reg, chars_before_next;
    phase_t           phase_reg, phase_next;
    depth_set_t       inner_reg, inner_next;
    logic             ended_reg, ended_next;
    logic             any_byte_reg, any_byte_next;

    logic [7:0]       b;
    count_t           outer_cnt;
    count_t           inner_cnt;
    logic             t_int;
    logic             t_void;
    logic             clear;
    verdict_t         verdict;

    assign b         = beat.data_byte;
    assign outer_cnt = count_bracket(depth_reg, b);
    assign inner_cnt = count_bracket(inner_reg, b);

    always_comb begin
        depth_next         = depth_reg;
        bracket_error_next = bracket_error_reg;
        incl_prog_next     = incl_prog_reg;
        include_seen_next  = include_seen_reg;
        recent_next        = recent_reg;
        type_win_next      = type_win_reg;
        chars_before_next  = chars_before_reg;
        phase_next         = phase_reg;
        inner_next         = inner_reg;
        ended_next         = ended_reg;
        any_byte_next      = any_byte_reg;
        t_int              = 1'b0;
        t_void             = 1'b0;

        if (!ended_reg) begin
            if (b == 8'h00) begin
                ended_next = 1'b1;
            end else begin
                any_byte_next = 1'b1;

                if (!bracket_error_reg) begin
                    depth_next = outer_cnt.depth;
                    if (!outer_cnt.ok) bracket_error_next = 1'b1;
                end

                if (!include_seen_reg) begin
                    if (incl_prog_reg < INCL_LEN && b == incl_char(incl_prog_reg[2:0])) begin
                        incl_prog_next = incl_prog_reg + 4'd1;
                    end else begin
                        incl_prog_next = (b == CH_HASH) ? 4'd1 : 4'd0;
                    end
                    if (incl_prog_next == INCL_LEN) include_seen_next = 1'b1;
                end

                case (phase_reg)
                    PH_OPEN_R: begin
                        if (b == CH_LPAREN) begin
                            inner_next = '0;
                            phase_next = PH_IN_R;
                        end else if (!is_ws(b)) begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_IN_R: begin
                        if (b == CH_RPAREN && inner_reg == '0) phase_next = PH_OPEN_C;
                        else if (!inner_cnt.ok) phase_next = PH_FAIL;
                        else inner_next = inner_cnt.depth;
                    end
                    PH_OPEN_C: begin
                        if (b == CH_LCURLY) begin
                            inner_next = '0;
                            phase_next = PH_IN_C;
                        end else if (!is_ws(b)) begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_IN_C: begin
                        if (b == CH_RCURLY && inner_reg == '0) phase_next = PH_FOUND;
                        else if (!inner_cnt.ok) phase_next = PH_FAIL;
                        else inner_next = inner_cnt.depth;
                    end
                    default: begin
                    end
                endcase

                // Start of a whitespace run: snapshot the word just before it.
                if (is_ws(b) && !is_ws(recent_reg[0])) begin
                    type_win_next = recent_reg[3:0];
                    if (recent_reg[0] == 8'h00)      chars_before_next = 3'd0;
                    else if (recent_reg[1] == 8'h00) chars_before_next = 3'd1;
                    else if (recent_reg[2] == 8'h00) chars_before_next = 3'd2;
                    else if (recent_reg[3] == 8'h00) chars_before_next = 3'd3;
                    else                             chars_before_next = 3'd4;
                end

                recent_next = {recent_reg[3:0], b};

                if (phase_reg == PH_IDLE && b == "n" && recent_reg[0] == "i" &&
                    recent_reg[1] == "a" && recent_reg[2] == "m" && is_ws(recent_reg[3])) begin
                    t_int  = chars_before_reg >= 3'd3 && to_lower(type_win_reg[2]) == "i" &&
                             to_lower(type_win_reg[1]) == "n" &&
                             to_lower(type_win_reg[0]) == "t";
                    t_void = chars_before_reg >= 3'd4 && to_lower(type_win_reg[3]) == "v" &&
                             to_lower(type_win_reg[2]) == "o" &&
                             to_lower(type_win_reg[1]) == "i" &&
                             to_lower(type_win_reg[0]) == "d";
                    phase_next = (t_int || t_void) ? PH_OPEN_R : PH_FAIL;
                end
            end
        end
    end

    always_comb begin
        if (!any_byte_next) begin
            verdict = VERDICT_EMPTY;
        end else if (bracket_error_next || depth_next != '0) begin
            verdict = VERDICT_BRACKET;
        end else if (include_seen_next) begin
            verdict = VERDICT_INCLUDE;
        end else if (phase_next == PH_FOUND) begin
            verdict = VERDICT_MAIN;
        end else begin
            verdict = VERDICT_TEXT;
        end
    end

    assign result.verdict = verdict;
    assign result.is_code = (verdict == VERDICT_INCLUDE) || (verdict == VERDICT_MAIN);
    assign res_valid      = fire && beat.last;

    // Drop all scan state once the last beat of a message has been classified.
    assign clear = !aresetn || res_valid;

    always_ff @(posedge aclk) begin
        if (clear) begin
            depth_reg         <= '0;
            bracket_error_reg <= 1'b0;
            incl_prog_reg     <= 4'd0;
            include_seen_reg  <= 1'b0;
            recent_reg        <= '0;
            type_win_reg      <= '0;
            chars_before_reg  <= 3'd0;
            phase_reg         <= PH_IDLE;
            inner_reg         <= '0;
            ended_reg         <= 1'b0;
            any_byte_reg      <= 1'b0;
        end else if (fire) begin
            depth_reg         <= depth_next;
            bracket_error_reg <= bracket_error_next;
            incl_prog_reg     <= incl_prog_next;
            include_seen_reg  <= include_seen_next;
            recent_reg        <= recent_next;
            type_win_reg      <= type_win_next;
            chars_before_reg  <= chars_before_next;
            phase_reg         <= phase_next;
            inner_reg         <= inner_next;
            ended_reg         <= ended_next;
            any_byte_reg      <= any_byte_next;
        end
    end

endmodule

FILE: hw/rtl/scd_out_stage.sv
`timescale 1ns / 1ps
// Output register of the source code detector: holds one result beat.
// Depends on scd_pkg for the result type.
module scd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  scd_pkg::result_t result,
    output logic             out_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata    // [0] is_code, [3:1] verdict, [7:4] zero
);
    import scd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, result_reg.verdict, result_reg.is_code};

endmodule

FILE: hw/rtl/source_code_detector_top.sv
`timescale 1ns / 1ps
// Source code detector: classifies a byte stream message as C source or not.
// Throughput: one byte beat per cycle; the input stalls only while a result waits on m_tready.
// The last beat passes through the input register, then its result is loaded into the result register.
// Per-byte work is one pass of the scan logic between the input and result registers.
// Reset: synchronous active-low aresetn empties both registers and clears all scan state.
// Depends on scd_pkg, scd_in_stage, scd_classifier and scd_out_stage.
module source_code_detector_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_code, [3:1] verdict, [7:4] zero
);
    import scd_pkg::*;

    beat_t   beat;
    logic    beat_valid;
    logic    advance;
    logic    fire;
    logic    res_valid;
    result_t result;

    assign fire = beat_valid && advance;

    scd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    scd_classifier u_cls (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .beat      (beat),
        .res_valid (res_valid),
        .result    (result)
    );

    scd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .result    (result),
        .out_ready (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: hw/rtl/scd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the source code detector, bound to the top level.
// Sees only the top-level ports; no package dependency.
module scd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Input backpressure only comes from a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // A fresh result follows an accepted last beat.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without an accepted last beat");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind source_code_detector_top scd_checker u_scd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
